// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps

package pds_pkg;

  // Pixel and sum widths
  localparam int PIX_W      = 16;
  localparam int VSUM_W     = PIX_W + 3;   // vertical sum, weights total 8
  localparam int WGT_W      = 4;           // a merged tap weight, 0..8
  localparam int HSUM_W     = VSUM_W + WGT_W;
  localparam int RND_SHIFT  = 6;           // total gain is 64
  localparam int RND_HALF   = 32;

  // Geometry
  localparam int ROW_W         = 16;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int RESET_WIDTH   = 2048;
  localparam int RESET_HEIGHT  = 1;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_WIDTH_W = 12;

  // Results one pixel can finish
  localparam int RES_MAX = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [WGT_W-1:0]       wgt_t;
  // Weight per window position; entry 0 belongs to the current column.
  typedef logic [3:0][WGT_W-1:0]  hwgt_t;

  // Update of one row buffer (one per output row parity)
  typedef struct packed {
    logic en;
    logic first;
    wgt_t wv;
  } vslot_t;

  // An output row that may finish on the current input row
  typedef struct packed {
    logic fin;
    logic last;
  } orow_t;

  // An output column that may finish on the current input column
  typedef struct packed {
    logic  ok;
    logic  row_end;
    hwgt_t hw;
  } ocol_t;

  // Horizontal pass control for one input pixel
  typedef struct packed {
    orow_t [1:0] orow;
    logic        par0;   // row buffer parity of the first output row
    ocol_t [1:0] ocol;
  } hctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } res_t;

endpackage

// ===== rtl/pds_in_if.sv =====
`timescale 1ns / 1ps

interface pds_in_if
  import pds_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);

endinterface

// ===== rtl/pds_out_if.sv =====
`timescale 1ns / 1ps

interface pds_out_if
  import pds_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_end;
  logic             frame_end;
  logic             run_last;

  modport source (
    output valid, output pixel_out, output row_end, output frame_end, output run_last,
    input ready
  );
  modport sink (
    input valid, input pixel_out, input row_end, input frame_end, input run_last,
    output ready
  );

endinterface

// ===== rtl/pds_vert.sv =====
`timescale 1ns / 1ps

// Vertical pass: two row buffers of partial column sums, one per output row
// parity. Each is read when a pixel is accepted and written with the
// accumulated value as the pixel leaves the input stage register, which
// a pipeline stall can hold back.
module pds_vert
  import pds_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [PIX_W-1:0]            px_i,
  input  vslot_t [1:0]                vs_i,
  output logic [1:0][VSUM_W-1:0]      sum_o
);

  localparam int PROD_W = WGT_W + PIX_W;

  for (genvar p = 0; p < 2; p++) begin : g_slot
    logic [VSUM_W-1:0] row_mem [MAX_WIDTH];
    logic [VSUM_W-1:0] rd_q;
    logic              fwd_q;
    logic [VSUM_W-1:0] fwd_data_q;
    logic [VSUM_W-1:0] old_sum;
    logic [PROD_W-1:0] prod;
    logic              wr_slot;

    assign wr_slot = wr_en_i && vs_i[p].en;

    // Weighted pixel, then either start a new partial sum or add to it.
    assign prod     = PROD_W'(vs_i[p].wv) * PROD_W'(px_i);
    assign old_sum  = fwd_q ? fwd_data_q : rd_q;
    assign sum_o[p] = vs_i[p].first ? prod[VSUM_W-1:0]
                                    : old_sum + prod[VSUM_W-1:0];

    // Row buffer with registered read.
    always_ff @(posedge clk_i) begin
      if (wr_slot) begin
        row_mem[wr_addr_i] <= sum_o[p];
      end
      if (rd_en_i) begin
        rd_q <= row_mem[rd_addr_i];
      end
    end

    // A read at the address written in the same cycle takes the new value.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fwd_q <= 1'b0;
      end else if (rd_en_i) begin
        fwd_q <= wr_slot && (rd_addr_i == wr_addr_i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        fwd_data_q <= sum_o[p];
      end
    end
  end

endmodule

// ===== rtl/pds_hout.sv =====
`timescale 1ns / 1ps

// Horizontal pass and result buffer. Keeps a four-column window of the
// finished vertical sums per row parity, applies the column weights and
// holds up to four results of one pixel, handed out one per cycle on res_o.ready.
module pds_hout
  import pds_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [1:0]             upd_en_i,
  input  logic [1:0][VSUM_W-1:0] sum_i,
  input  hctrl_t                 hctrl_i,
  output logic                   advance_o,
  pds_out_if.source              res_o
);

  logic [VSUM_W-1:0]  win_q [2][4];
  logic               st2_valid_q;
  hctrl_t             st2_q;
  logic [RES_MAX-1:0] pack_valid;
  res_t [RES_MAX-1:0] pack;
  logic [RES_MAX-1:0] g_valid_q;
  res_t [RES_MAX-1:0] g_q;
  logic               out_acc;

  // The pipeline moves when the result buffer is empty or gives its last entry.
  assign advance_o = !g_valid_q[0] || (!g_valid_q[1] && res_o.ready);
  assign out_acc   = res_o.valid && res_o.ready;

  // Sample windows, newest column in position 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        for (int k = 0; k < 4; k++) begin
          win_q[p][k] <= '0;
        end
      end
    end else if (advance_o && load_i) begin
      for (int p = 0; p < 2; p++) begin
        if (upd_en_i[p]) begin
          win_q[p][0] <= sum_i[p];
          for (int k = 1; k < 4; k++) begin
            win_q[p][k] <= win_q[p][k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_valid_q <= 1'b0;
    end else if (advance_o) begin
      st2_valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      st2_q <= hctrl_i;
    end
  end

  // Filter every finished output pixel and pack them by row, then column.
  always_comb begin
    logic [HSUM_W-1:0] acc;
    logic [HSUM_W-1:0] rnd;
    logic              slot;
    logic              cvalid;
    logic [2:0]        cnt;
    pack_valid = '0;
    pack       = '0;
    cnt        = '0;
    for (int d = 0; d < 2; d++) begin
      for (int e = 0; e < 2; e++) begin
        slot = (d == 0) ? st2_q.par0 : !st2_q.par0;
        acc  = '0;
        for (int k = 0; k < 4; k++) begin
          acc = acc + HSUM_W'(st2_q.ocol[e].hw[k]) * HSUM_W'(win_q[slot][k]);
        end
        rnd    = acc + HSUM_W'(RND_HALF);
        cvalid = st2_valid_q && st2_q.orow[d].fin && st2_q.ocol[e].ok;
        if (cvalid) begin
          pack_valid[cnt[1:0]]    = 1'b1;
          pack[cnt[1:0]].pix      = rnd[PIX_W+RND_SHIFT-1:RND_SHIFT];
          pack[cnt[1:0]].row_end  = st2_q.ocol[e].row_end;
          pack[cnt[1:0]].frame_end = st2_q.ocol[e].row_end && st2_q.orow[d].last;
          cnt = cnt + 3'd1;
        end
      end
    end
  end

  // Result buffer: loads a whole group, shifts down by one per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= '0;
    end else if (advance_o) begin
      g_valid_q <= pack_valid;
    end else if (out_acc) begin
      g_valid_q <= {1'b0, g_valid_q[RES_MAX-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      g_q <= pack;
    end else if (out_acc) begin
      for (int k = 0; k < RES_MAX - 1; k++) begin
        g_q[k] <= g_q[k+1];
      end
    end
  end

  assign res_o.valid     = g_valid_q[0];
  assign res_o.pixel_out = g_q[0].pix;
  assign res_o.row_end   = g_q[0].row_end;
  assign res_o.frame_end = g_q[0].frame_end;
  assign res_o.run_last  = !g_valid_q[1];

`ifndef ASSERT_OFF
  a_group_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_valid_q == 4'b0000) || (g_valid_q == 4'b0001) || (g_valid_q == 4'b0011) ||
    (g_valid_q == 4'b0111) || (g_valid_q == 4'b1111))
    else $error("result buffer entries are not packed from the head");

  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> res_o.row_end)
    else $error("frame end without row end");
`endif

endmodule

// ===== rtl/pyramid_downscale_2x_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                                        Transaction
// pix_i     in   valid, ready, pixel_in                         one input pixel, raster order
// res_o     out  valid, ready, pixel_out, row_end, frame_end,   one output pixel
//                run_last
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                register write, no back-pressure
//
// One input pixel is taken per clock while pix_i.ready is high; a result passes the input
// stage, window stage and result buffer. A pixel that finishes several outputs holds the
// input until its last result leaves, one result per clock while res_o is ready.
// Reset clears the counters, the pipeline and the result buffer and sets width 2048
// (at most MAX_WIDTH), height 1; the row buffers are not cleared.
// A stall on res_o freezes the whole pipeline; pix_i.ready follows the result buffer.
module pyramid_downscale_2x_top
  import pds_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pds_in_if.sink                pix_i,
  pds_out_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CIW         = $clog2(MAX_WIDTH);
  localparam int RESET_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam logic [1:0] TAP_W [4] = '{2'd1, 2'd3, 2'd3, 2'd1};

  // Tap position 2k-1+t clamped to 0..last.
  function automatic logic [ROW_W+1:0] clamp_tap(logic [ROW_W-1:0] k, logic [1:0] t,
                                                 logic [ROW_W-1:0] last);
    logic [ROW_W+1:0] p;
    p = {1'b0, k, 1'b0} + {{ROW_W{1'b0}}, t};
    if (p != '0) begin
      p = p - (ROW_W+2)'(1);
    end
    if (p > {2'b00, last}) begin
      p = {2'b00, last};
    end
    return p;
  endfunction

  // Position at which output index k is complete.
  function automatic logic [ROW_W+1:0] finish_at(logic [ROW_W-1:0] k, logic [ROW_W-1:0] last);
    logic [ROW_W+1:0] p;
    p = {1'b0, k, 1'b0} + (ROW_W+2)'(2);
    return (p > {2'b00, last}) ? {2'b00, last} : p;
  endfunction

  // Merged weight of all taps of output k that land on position pos.
  function automatic wgt_t tap_hit(logic [ROW_W-1:0] k, logic [ROW_W-1:0] pos,
                                   logic [ROW_W-1:0] last);
    wgt_t acc;
    acc = '0;
    for (int t = 0; t < 4; t++) begin
      if (clamp_tap(k, 2'(t), last) == {2'b00, pos}) begin
        acc = acc + WGT_W'(TAP_W[t]);
      end
    end
    return acc;
  endfunction

  // Weights of output k over the window ending at position pos.
  function automatic hwgt_t tap_spread(logic [ROW_W-1:0] k, logic [ROW_W-1:0] pos,
                                       logic [ROW_W-1:0] last);
    hwgt_t            hw;
    logic [ROW_W+1:0] diff;
    hw = '0;
    for (int t = 0; t < 4; t++) begin
      diff = {2'b00, pos} - clamp_tap(k, 2'(t), last);
      if (diff < (ROW_W+2)'(4)) begin
        hw[diff[1:0]] = hw[diff[1:0]] + WGT_W'(TAP_W[t]);
      end
    end
    return hw;
  endfunction

  // Written width to last column index, with out-of-range widths clamped.
  function automatic logic [CIW-1:0] width_last(logic [CFG_WIDTH_W-1:0] v);
    logic [CIW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      r = CIW'(MAX_WIDTH - 1);
    end else begin
      r = CIW'(v - CFG_WIDTH_W'(1));
    end
    return r;
  endfunction

  logic [CIW-1:0]         wlast_q;
  logic [ROW_W-1:0]       hlast_q;
  logic [CIW-1:0]         col_q;
  logic [ROW_W-1:0]       row_q;
  logic                   advance;
  logic                   accept;
  vslot_t [1:0]           dec_vs;
  hctrl_t                 dec_h;
  logic                   st1_valid_q;
  logic [PIX_W-1:0]       st1_px_q;
  logic [CIW-1:0]         st1_col_q;
  vslot_t [1:0]           st1_vs_q;
  hctrl_t                 st1_h_q;
  logic [1:0][VSUM_W-1:0] vsum;
  logic [1:0]             upd_en;

  assign pix_i.ready = advance;
  assign accept      = pix_i.valid && advance;

  // Configuration registers hold the last index of each dimension.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CIW'(RESET_W_EFF - 1);
      hlast_q <= ROW_W'(RESET_HEIGHT - 1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH: begin
          wlast_q <= width_last(cfg_data_i[CFG_WIDTH_W-1:0]);
        end
        REG_HEIGHT: begin
          hlast_q <= (cfg_data_i[ROW_W-1:0] == '0) ? '0
                                                   : cfg_data_i[ROW_W-1:0] - ROW_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position of the next pixel; any register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_q <= '0;
        row_q <= (row_q == hlast_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + CIW'(1);
      end
    end
  end

  // Decode which output rows and columns this pixel feeds and finishes.
  always_comb begin
    logic [ROW_W-1:0] c16;
    logic [ROW_W-1:0] wl16;
    logic [ROW_W-1:0] ilo;
    logic [ROW_W-1:0] jlo;
    logic [ROW_W-1:0] ii;
    logic [ROW_W-1:0] jj;
    logic             iok;
    vslot_t           cand [2];
    dec_vs = '0;
    dec_h  = '0;
    c16    = ROW_W'(col_q);
    wl16   = ROW_W'(wlast_q);
    ilo    = (row_q == '0) ? '0 : (row_q - ROW_W'(1)) >> 1;
    jlo    = (c16 == '0) ? '0 : (c16 - ROW_W'(1)) >> 1;
    for (int d = 0; d < 2; d++) begin
      ii            = ilo + ROW_W'(d);
      iok           = ii <= (hlast_q >> 1);
      cand[d].wv    = tap_hit(ii, row_q, hlast_q);
      cand[d].first = clamp_tap(ii, 2'd0, hlast_q) == {2'b00, row_q};
      cand[d].en    = iok && (cand[d].wv != '0);
      dec_h.orow[d].fin  = iok && (finish_at(ii, hlast_q) == {2'b00, row_q});
      dec_h.orow[d].last = ii == (hlast_q >> 1);
    end
    dec_h.par0 = ilo[0];
    if (ilo[0]) begin
      dec_vs[1] = cand[0];
      dec_vs[0] = cand[1];
    end else begin
      dec_vs[0] = cand[0];
      dec_vs[1] = cand[1];
    end
    for (int e = 0; e < 2; e++) begin
      jj = jlo + ROW_W'(e);
      dec_h.ocol[e].ok      = (jj <= (wl16 >> 1)) && (finish_at(jj, wl16) == {2'b00, c16});
      dec_h.ocol[e].row_end = jj == (wl16 >> 1);
      dec_h.ocol[e].hw      = tap_spread(jj, c16, wl16);
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
    end else if (advance) begin
      st1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st1_px_q  <= pix_i.pixel_in;
      st1_col_q <= col_q;
      st1_vs_q  <= dec_vs;
      st1_h_q   <= dec_h;
    end
  end

  assign upd_en = {st1_vs_q[1].en, st1_vs_q[0].en};

  pds_vert #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_vert (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (advance && st1_valid_q),
    .wr_addr_i (st1_col_q),
    .px_i      (st1_px_q),
    .vs_i      (st1_vs_q),
    .sum_o     (vsum)
  );

  pds_hout u_hout (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (st1_valid_q),
    .upd_en_i  (upd_en),
    .sum_i     (vsum),
    .hctrl_i   (st1_h_q),
    .advance_o (advance),
    .res_o     (res_o)
  );

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= wlast_q) && (row_q <= hlast_q))
    else $error("raster position outside the configured image");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("register write did not restart the frame");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st1_valid_q)
    else $error("accepted pixel missing from the input stage");
`endif

endmodule
